>>> rtl/core/np_bal_pkg.sv
// ----------------------------------------------------------------------------
// np_bal_pkg
// Shared constants, register indexes and types for the neutral-point balance
// controller and monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package np_bal_pkg;

    localparam int VOLT_BITS_DEF  = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LIMIT_W   = 15;
    localparam int DUTY_W    = 16;
    localparam int FRAC_BITS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN            = 3'd0,
        REG_OFFSET_LIMIT    = 3'd1,
        REG_WARN_THRESHOLD  = 3'd2,
        REG_WARN_COUNT      = 3'd3,
        REG_FAULT_THRESHOLD = 3'd4,
        REG_FAULT_COUNT     = 3'd5
    } cfg_reg_t;

    localparam logic [CFG_W-1:0]   GAIN_RST            = 16'd1311;
    localparam logic [LIMIT_W-1:0] OFFSET_LIMIT_RST    = 15'd3277;
    localparam logic [CFG_W-1:0]   WARN_THRESHOLD_RST  = 16'd1280;
    localparam logic [CFG_W-1:0]   WARN_COUNT_RST      = 16'd1000;
    localparam logic [CFG_W-1:0]   FAULT_THRESHOLD_RST = 16'd3200;
    localparam logic [CFG_W-1:0]   FAULT_COUNT_RST     = 16'd100;

    typedef struct packed {
        logic warn_event;
        logic fault_request;
    } alarm_status_t;

endpackage

`default_nettype wire

>>> rtl/core/np_bal_ctrl.sv
// ----------------------------------------------------------------------------
// np_bal_ctrl
// Error, absolute error and clamped proportional duty offset for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module np_bal_ctrl
    import np_bal_pkg::*;
#(
    parameter int VOLT_BITS = VOLT_BITS_DEF
)
(
    input  wire logic [VOLT_BITS-1:0] v_top,
    input  wire logic [VOLT_BITS-1:0] v_bottom,
    input  wire logic [CFG_W-1:0]     gain,
    input  wire logic [LIMIT_W-1:0]   offset_limit,
    output logic signed [VOLT_BITS:0] np_error,
    output logic [VOLT_BITS-1:0]      err_mag,
    output logic signed [DUTY_W-1:0]  duty_offset
);

    localparam int PROD_W = VOLT_BITS + CFG_W;
    localparam int Q_W    = PROD_W + 1 - FRAC_BITS;

    logic                neg;
    logic [VOLT_BITS:0]  err_neg;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W:0]     prod_up;
    logic [Q_W-1:0]      quot;
    logic [LIMIT_W-1:0]  quot_clamped;
    logic [DUTY_W-1:0]   duty_mag;

    assign np_error = $signed({1'b0, v_top} - {1'b0, v_bottom});
    assign neg      = np_error[VOLT_BITS];
    assign err_neg  = -np_error;
    assign err_mag  = neg ? err_neg[VOLT_BITS-1:0] : np_error[VOLT_BITS-1:0];

    assign prod    = PROD_W'(err_mag) * PROD_W'(gain);
    // round the magnitude up for negative error: floor of the signed quotient
    assign prod_up = {1'b0, prod} + (PROD_W + 1)'((1 << FRAC_BITS) - 1);

    always_comb
    begin
        if (neg)
        begin
            quot = prod_up[PROD_W:FRAC_BITS];
        end
        else
        begin
            quot = {1'b0, prod[PROD_W-1:FRAC_BITS]};
        end
        if (quot > Q_W'(offset_limit))
        begin
            quot_clamped = offset_limit;
        end
        else
        begin
            quot_clamped = quot[LIMIT_W-1:0];
        end
    end

    assign duty_mag    = {1'b0, quot_clamped};
    assign duty_offset = neg ? $signed(-duty_mag) : $signed(duty_mag);

endmodule

`default_nettype wire

>>> rtl/core/np_bal_alarm.sv
// ----------------------------------------------------------------------------
// np_bal_alarm
// Warning and fault debounce counters on the absolute error.
// ----------------------------------------------------------------------------
`default_nettype none

module np_bal_alarm
    import np_bal_pkg::*;
#(
    parameter int VOLT_BITS  = VOLT_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 update,
    input  wire logic [VOLT_BITS-1:0] err_mag,
    input  wire logic [CFG_W-1:0]     warn_threshold,
    input  wire logic [CFG_W-1:0]     warn_count,
    input  wire logic [CFG_W-1:0]     fault_threshold,
    input  wire logic [CFG_W-1:0]     fault_count,
    output alarm_status_t             status
);

    localparam int TH_W  = (VOLT_BITS > CFG_W) ? VOLT_BITS : CFG_W;
    localparam int CMP_W = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] warn_ticks_reg,  warn_ticks_next;
    logic [COUNT_BITS-1:0] fault_ticks_reg, fault_ticks_next;
    logic                  warn_over;
    logic                  fault_over;
    logic [COUNT_BITS-1:0] warn_inc;
    logic [COUNT_BITS-1:0] fault_inc;
    logic [CMP_W-1:0]      warn_count_x;
    logic [CMP_W-1:0]      fault_count_x;

    assign warn_over     = TH_W'(err_mag) > TH_W'(warn_threshold);
    assign fault_over    = TH_W'(err_mag) > TH_W'(fault_threshold);
    assign warn_count_x  = CMP_W'(warn_count);
    assign fault_count_x = CMP_W'(fault_count);
    assign warn_inc  = (warn_ticks_reg  < CNT_MAX) ? warn_ticks_reg  + 1'b1 : warn_ticks_reg;
    assign fault_inc = (fault_ticks_reg < CNT_MAX) ? fault_ticks_reg + 1'b1 : fault_ticks_reg;

    always_comb
    begin
        status           = '0;
        warn_ticks_next  = '0;
        fault_ticks_next = '0;
        if (warn_over)
        begin
            if (CMP_W'(warn_ticks_reg) >= warn_count_x)
            begin
                warn_ticks_next = warn_count_x[COUNT_BITS-1:0];
            end
            else
            begin
                warn_ticks_next   = warn_inc;
                status.warn_event = (CMP_W'(warn_inc) == warn_count_x);
            end
        end
        if (fault_over)
        begin
            if (CMP_W'(fault_inc) >= fault_count_x)
            begin
                fault_ticks_next     = fault_count_x[COUNT_BITS-1:0];
                status.fault_request = 1'b1;
            end
            else
            begin
                fault_ticks_next = fault_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_ticks_reg  <= '0;
            fault_ticks_reg <= '0;
        end
        else if (update)
        begin
            warn_ticks_reg  <= warn_ticks_next;
            fault_ticks_reg <= fault_ticks_next;
        end
    end

    a_warn_clear : assert property (@(posedge clk) disable iff (!rst_n)
        update && !warn_over |=> warn_ticks_reg == '0)
        else $error("warning counter not cleared");

    a_warn_event_count : assert property (@(posedge clk) disable iff (!rst_n)
        update && status.warn_event |=> CMP_W'(warn_ticks_reg) == $past(warn_count_x))
        else $error("warning event without reaching count");

    a_fault_over : assert property (@(posedge clk) disable iff (!rst_n)
        status.fault_request |-> fault_over)
        else $error("fault request below threshold");

    a_fault_hold : assert property (@(posedge clk) disable iff (!rst_n)
        update && status.fault_request |=> CMP_W'(fault_ticks_reg) == $past(fault_count_x))
        else $error("fault counter not held at count");

endmodule

`default_nettype wire

>>> rtl/core/np_balance_p_control_monitor.sv
// ----------------------------------------------------------------------------
// np_balance_p_control_monitor
// Neutral-point balance P controller with debounced imbalance alarms.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   v_top, v_bottom
//   m_*      out  m_tvalid/m_tready   duty_offset, np_error, warn_event,
//                                     fault_request
//   cfg_*    in   cfg_we              cfg_index, cfg_data
//
// One request per cycle sustained while m_tready is high. A request loads the
// input register on accept and the result register once the output is free.
// The multiply, clamp and counter updates sit between those two registers.
// Reset loads the register defaults and clears both counters.
// A stalled result holds; the input register still takes one request behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module np_balance_p_control_monitor
    import np_bal_pkg::*;
#(
    parameter int VOLT_BITS  = VOLT_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // v_top, v_bottom, zero pad
    input  wire logic [((2*VOLT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // duty_offset, np_error, warn_event, fault_request, zero pad
    output logic [((VOLT_BITS+DUTY_W+3+7)/8)*8-1:0] m_tdata,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int OUT_W  = ((VOLT_BITS + DUTY_W + 3 + 7) / 8) * 8;

    logic [CFG_W-1:0]   gain_reg;
    logic [LIMIT_W-1:0] offset_limit_reg;
    logic [CFG_W-1:0]   warn_threshold_reg;
    logic [CFG_W-1:0]   warn_count_reg;
    logic [CFG_W-1:0]   fault_threshold_reg;
    logic [CFG_W-1:0]   fault_count_reg;

    logic                 in_valid_reg;
    logic [VOLT_BITS-1:0] v_top_reg;
    logic [VOLT_BITS-1:0] v_bottom_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic                     advance;
    logic                     load_in;
    logic signed [VOLT_BITS:0] np_error;
    logic [VOLT_BITS-1:0]     err_mag;
    logic signed [DUTY_W-1:0] duty_offset;
    alarm_status_t            status;
    logic [OUT_W-1:0]         out_data_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg            <= GAIN_RST;
            offset_limit_reg    <= OFFSET_LIMIT_RST;
            warn_threshold_reg  <= WARN_THRESHOLD_RST;
            warn_count_reg      <= WARN_COUNT_RST;
            fault_threshold_reg <= FAULT_THRESHOLD_RST;
            fault_count_reg     <= FAULT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:            gain_reg            <= cfg_data;
                REG_OFFSET_LIMIT:    offset_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_WARN_THRESHOLD:  warn_threshold_reg  <= cfg_data;
                REG_WARN_COUNT:      warn_count_reg      <= cfg_data;
                REG_FAULT_THRESHOLD: fault_threshold_reg <= cfg_data;
                REG_FAULT_COUNT:     fault_count_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            v_top_reg    <= s_tdata[VOLT_BITS-1:0];
            v_bottom_reg <= s_tdata[2*VOLT_BITS-1:VOLT_BITS];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    np_bal_ctrl #(
        .VOLT_BITS (VOLT_BITS)
    ) u_ctrl (
        .v_top        (v_top_reg),
        .v_bottom     (v_bottom_reg),
        .gain         (gain_reg),
        .offset_limit (offset_limit_reg),
        .np_error     (np_error),
        .err_mag      (err_mag),
        .duty_offset  (duty_offset)
    );

    np_bal_alarm #(
        .VOLT_BITS  (VOLT_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_alarm (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (advance),
        .err_mag         (err_mag),
        .warn_threshold  (warn_threshold_reg),
        .warn_count      (warn_count_reg),
        .fault_threshold (fault_threshold_reg),
        .fault_count     (fault_count_reg),
        .status          (status)
    );

    assign out_data_next = OUT_W'({status.fault_request, status.warn_event,
                                   np_error, duty_offset});

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
